[rtl/core/sedge_pkg.sv]
package sedge_pkg;

  localparam int PIX_W       = 8;
  localparam int DIM_W       = 11;
  localparam int THR_W       = 8;
  localparam int POS_W       = 10;
  localparam int GRAD_W      = 8;
  localparam int CALC_W      = 13;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_W-1:0] RST_WIDTH     = DIM_W'(512);
  localparam logic [DIM_W-1:0] RST_HEIGHT    = DIM_W'(512);
  localparam logic [THR_W-1:0] RST_THRESHOLD = '0;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } sedge_tag_t;

  // index of the last pixel along one dimension, size clamped to 3..max
  function automatic logic [CALC_W-1:0] last_index(logic [DIM_W-1:0] raw,
                                                   logic [CALC_W-1:0] maxv);
    logic [CALC_W-1:0] ext;
    ext = CALC_W'(raw);
    if (ext < CALC_W'(3)) begin
      last_index = CALC_W'(2);
    end else if (ext > maxv) begin
      last_index = maxv - CALC_W'(1);
    end else begin
      last_index = ext - CALC_W'(1);
    end
  endfunction

  // positive part minus negative part, clamped to 0..255
  function automatic logic [GRAD_W-1:0] clamp_grad(logic [9:0] pos, logic [9:0] neg);
    logic [10:0] diff;
    diff = {1'b0, pos} - {1'b0, neg};
    if (diff[10]) begin
      clamp_grad = '0;
    end else if (diff[9:8] != 2'b00) begin
      clamp_grad = '1;
    end else begin
      clamp_grad = diff[7:0];
    end
  endfunction

endpackage

[rtl/core/sobel_edge_threshold_stream_top.sv]
// channel   | dir | handshake          | payload
// pixel in  | in  | s_tvalid/s_tready  | s_tdata: pixel_value
// result    | out | m_tvalid/m_tready  | m_tdata: row, col, grad_x, grad_y, edge; m_tlast
// config    | in  | psel/penable/pready| paddr, pwdata, pwrite; prdata
//
// one pixel per cycle unless m_tready stalls; a result leaves through these registered steps:
// line buffer read, window shift with buffer write back, gradient into output register
// the two line buffers share one read and one write port, each used once per pixel
// rst clears position, window and pipeline valids; line buffers are not cleared
// a stalled m_tready fills the output register, the window stage and the read stage,
// then s_tready drops
module sobel_edge_threshold_stream_top
  import sedge_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] center_row, [19:10] center_col,
                                            // [27:20] grad_x, [35:28] grad_y,
                                            // [43:36] edge_value, [47:44] zero
  output logic                   m_tlast,   // frame_last
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [THR_W-1:0] edge_threshold;
  logic             cfg_we;
  logic [CW-1:0]    col_last;
  logic [RW-1:0]    row_last;

  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic             accept;

  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_px;
  sedge_tag_t       s1_tag;
  logic             s1_fwd;
  logic [PIX_W-1:0] s1_fwd_top;
  logic [PIX_W-1:0] s1_fwd_mid;
  logic             s1_move;
  logic [PIX_W-1:0] s1_top;
  logic [PIX_W-1:0] s1_mid;
  logic [PIX_W-1:0] rd_upper;
  logic [PIX_W-1:0] rd_middle;
  logic             s2_free;
  sedge_tag_t       tag_next;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_WIDTH;
      image_height   <= RST_HEIGHT;
      edge_threshold <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WIDTH:     image_width    <= pwdata[DIM_W-1:0];
        REG_HEIGHT:    image_height   <= pwdata[DIM_W-1:0];
        REG_THRESHOLD: edge_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:     prdata = APB_DATA_W'(image_width);
      REG_HEIGHT:    prdata = APB_DATA_W'(image_height);
      REG_THRESHOLD: prdata = APB_DATA_W'(edge_threshold);
      default:       prdata = '0;
    endcase
  end

  assign col_last = CW'(last_index(image_width, CALC_W'(MAX_WIDTH)));
  assign row_last = RW'(last_index(image_height, CALC_W'(MAX_HEIGHT)));

  assign s1_move  = s1_valid && s2_free;
  assign s_tready = !s1_valid || s2_free;
  assign accept   = s_tvalid && s_tready;

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_we && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_comb begin
    tag_next.emit = (row >= RW'(2)) && (col >= CW'(2));
    tag_next.last = (row == row_last) && (col == col_last);
    tag_next.row  = POS_W'(row - 1'b1);
    tag_next.col  = POS_W'(col - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // same column written back by the item ahead: take its values
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col;
      s1_px      <= s_tdata[PIX_W-1:0];
      s1_tag     <= tag_next;
      s1_fwd     <= s1_valid && (s1_col == col);
      s1_fwd_top <= s1_mid;
      s1_fwd_mid <= s1_px;
    end
  end

  assign s1_top = s1_fwd ? s1_fwd_top : rd_upper;
  assign s1_mid = s1_fwd ? s1_fwd_mid : rd_middle;

  sedge_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (s1_move),
    .wr_addr   (s1_col),
    .wr_upper  (s1_mid),
    .wr_middle (s1_px)
  );

  sedge_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .shift     (s1_move),
    .top       (s1_top),
    .mid       (s1_mid),
    .px        (s1_px),
    .tag       (s1_tag),
    .threshold (edge_threshold),
    .free      (s2_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (col <= col_last) && (row <= row_last))
    else $error("raster position beyond frame size");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> s1_move)
    else $error("read stage overwritten before it moved on");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_free) |=> (s1_valid && $stable(s1_col)))
    else $error("stalled read stage lost its item");

  a_fwd_unused_col: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> (s1_col != col))
    else $error("back to back beats on the same line buffer column");

endmodule

[rtl/core/sedge_linebuf.sv]
module sedge_linebuf
  import sedge_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_upper,
  output logic [PIX_W-1:0] rd_middle,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_upper,
  input  logic [PIX_W-1:0] wr_middle
);

  logic [PIX_W-1:0] mem_upper  [DEPTH];
  logic [PIX_W-1:0] mem_middle [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr]  <= wr_upper;
      mem_middle[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= mem_upper[rd_addr];
      rd_middle <= mem_middle[rd_addr];
    end
  end

endmodule

[rtl/core/sedge_grad.sv]
module sedge_grad
  import sedge_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [PIX_W-1:0]       top,
  input  logic [PIX_W-1:0]       mid,
  input  logic [PIX_W-1:0]       px,
  input  sedge_tag_t             tag,
  input  logic [THR_W-1:0]       threshold,
  output logic                   free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  logic [PIX_W-1:0] win [9];
  logic             s2_valid;
  sedge_tag_t       s2_tag;
  logic             out_free;

  logic [9:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GRAD_W-1:0] gx, gy;
  logic [8:0]        gsum;
  logic [GRAD_W-1:0] gsat, edge_val;

  assign out_free = !m_tvalid || m_tready;
  assign free     = !s2_valid || out_free;

  // window rows top to bottom, columns left to right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (shift) begin
      s2_valid <= tag.emit;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s2_tag <= tag;
    end
  end

  always_comb begin
    gx_pos   = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(win[8]);
    gx_neg   = 10'(win[0]) + {1'b0, win[3], 1'b0} + 10'(win[6]);
    gy_pos   = 10'(win[6]) + {1'b0, win[7], 1'b0} + 10'(win[8]);
    gy_neg   = 10'(win[0]) + {1'b0, win[1], 1'b0} + 10'(win[2]);
    gx       = clamp_grad(gx_pos, gx_neg);
    gy       = clamp_grad(gy_pos, gy_neg);
    gsum     = 9'(gx) + 9'(gy);
    gsat     = gsum[8] ? '1 : gsum[7:0];
    edge_val = (gsat > threshold) ? gsat : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      m_tdata <= {4'b0000, edge_val, gy, gx, s2_tag.col, s2_tag.row};
      m_tlast <= s2_tag.last;
    end
  end

endmodule

[test/sobel_edge_checker.sv]
module sobel_edge_checker
  import sedge_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  input  logic                   pready,
  output int                     mismatch_count,
  output int                     awaiting,
  output int                     checked
);

  localparam int REPORT_LIMIT = 20;

  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [GRAD_W-1:0] grad_x;
    logic [GRAD_W-1:0] grad_y;
    logic [GRAD_W-1:0] magnitude;
    logic              last;
  } edge_result_t;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [THR_W-1:0] thr_reg;
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [PIX_W-1:0] window_px [9];
  int unsigned      col_pos;
  int unsigned      row_pos;
  edge_result_t     expected_q [$];
  int               fails = 0;
  int               seen = 0;

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] raw, int unsigned lim);
    if (raw < 3) begin
      return 3;
    end
    if (raw > lim) begin
      return lim;
    end
    return int'(raw);
  endfunction

  function automatic logic [GRAD_W-1:0] sat_byte(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > 255) begin
      return '1;
    end
    return GRAD_W'(v);
  endfunction

  function automatic bit field_bad(string label, logic [15:0] want, logic [15:0] got);
    if (got === want) begin
      return 0;
    end
    if (fails < REPORT_LIMIT) begin
      $display("%0t: %s expected %0d got %0d", $time, label, want, got);
    end
    return 1;
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] beside;
    int               p [9];
    int               gx;
    int               gy;
    int               total;
    edge_result_t     res;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    above = upper_row[c];
    beside = middle_row[c];
    upper_row[c] = beside;
    middle_row[c] = px;
    for (int k = 0; k < 3; k++) begin
      window_px[k*3] = window_px[k*3+1];
      window_px[k*3+1] = window_px[k*3+2];
    end
    window_px[2] = above;
    window_px[5] = beside;
    window_px[8] = px;
    if (r >= 2 && c >= 2) begin
      for (int k = 0; k < 9; k++) begin
        p[k] = int'(window_px[k]);
      end
      gx = -p[0] + p[2] - 2 * p[3] + 2 * p[5] - p[6] + p[8];
      gy = -p[0] - 2 * p[1] - p[2] + p[6] + 2 * p[7] + p[8];
      res.grad_x = sat_byte(gx);
      res.grad_y = sat_byte(gy);
      total = int'(res.grad_x) + int'(res.grad_y);
      if (total > 255) begin
        total = 255;
      end
      res.row = POS_W'(r - 1);
      res.col = POS_W'(c - 1);
      res.magnitude = (total > int'(thr_reg)) ? GRAD_W'(total) : '0;
      res.last = (r == h - 1 && c == w - 1);
      expected_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic check_result();
    edge_result_t want;
    bit           bad;
    if (expected_q.size() == 0) begin
      if (fails < REPORT_LIMIT) begin
        $display("%0t: result beat expected none got tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
      end
      fails++;
    end else begin
      want = expected_q.pop_front();
      bad = 0;
      bad |= field_bad("center_row", want.row, m_tdata[9:0]);
      bad |= field_bad("center_col", want.col, m_tdata[19:10]);
      bad |= field_bad("grad_x", want.grad_x, m_tdata[27:20]);
      bad |= field_bad("grad_y", want.grad_y, m_tdata[35:28]);
      bad |= field_bad("edge_value", want.magnitude, m_tdata[43:36]);
      bad |= field_bad("tdata pad", '0, m_tdata[47:44]);
      bad |= field_bad("frame_last", want.last, m_tlast);
      if (bad) begin
        fails++;
      end
      seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      thr_reg = RST_THRESHOLD;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) begin
        window_px[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_WIDTH: begin
            width_reg = pwdata[DIM_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_HEIGHT: begin
            height_reg = pwdata[DIM_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_THRESHOLD: begin
            thr_reg = pwdata[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        take_pixel(s_tdata[PIX_W-1:0]);
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
    end
    mismatch_count <= fails;
    awaiting <= expected_q.size();
    checked <= seen;
  end

endmodule

[test/tb_sobel_edge_threshold_stream_top.sv]
module tb_sobel_edge_threshold_stream_top;
  import sedge_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PIXELS = 720;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_FLAT} pix_style_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int mismatch_count;
  int awaiting;
  int checked;
  int idle_cycles = 0;
  int pixels_sent = 0;
  int settings = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  sobel_edge_threshold_stream_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sobel_edge_checker u_sobel_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .awaiting       (awaiting),
    .checked        (checked)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink with random back-pressure
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] keep;
    // upper bits beyond the register width carry noise
    keep = (idx == REG_THRESHOLD) ? 32'h0000_00FF : 32'h0000_07FF;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & ~keep) | (value & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic drain_results(input bit settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  function automatic logic [PIX_W-1:0] next_pixel(pix_style_t style, logic [PIX_W-1:0] base);
    case (style)
      PIX_UNIFORM: return PIX_W'($urandom_range(0, 255));
      PIX_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:     return base + PIX_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [THR_W-1:0] thr, input int count,
                           input pix_style_t style, input bit dims);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom_range(0, 248));
    drain_results(1'b1);
    if (dims) begin
      reg_write(REG_WIDTH, w);
      reg_write(REG_HEIGHT, h);
    end
    reg_write(REG_THRESHOLD, thr);
    settings++;
    repeat (count) begin
      // occasionally hold off until the pipe is empty
      if ($urandom_range(0, 63) == 0) begin
        drain_results(1'b0);
      end
      send_pixel(next_pixel(style, base));
    end
  endtask

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [THR_W-1:0] thr;
    pix_style_t       style;
    int               start_count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // diagonal step frame with one flipped column, unused address write first
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    reg_write(REG_WIDTH, 11'd5);
    reg_write(REG_HEIGHT, 11'd5);
    reg_write(REG_THRESHOLD, 8'd0);
    settings++;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        send_pixel(((c < r) ^ (c == 4)) ? 8'hFF : 8'h00);
      end
    end

    // undersized dims clamp up, oversized height clamps down, full threshold
    run_phase(11'd0, 11'd1, 8'd255, 27, PIX_UNIFORM, 1'b1);
    run_phase(11'd4, 11'd2047, THR_W'($urandom_range(0, 255)), 240, PIX_UNIFORM, 1'b1);
    run_phase(11'd3, 11'd1024, 8'd100, 120, PIX_BINARY, 1'b1);

    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2))
                                       : DIM_W'($urandom_range(3, 12));
      h = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 2))
                                       : DIM_W'($urandom_range(3, 8));
      style = pix_style_t'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: thr = '0;
        1: thr = '1;
        2: thr = THR_W'($urandom_range(0, 255));
        default: thr = THR_W'($urandom_range(0, 30));
      endcase
      if (style == PIX_FLAT && $urandom_range(0, 1)) begin
        thr = THR_W'($urandom_range(0, 24));
      end
      run_phase(w, h, thr, $urandom_range(10, 160), style, $urandom_range(0, 4) != 0);
    end

    no_idle = 1'b0;
    drain_results(1'b1);
    $display("run covered %0d pixels over %0d register settings", pixels_sent, settings);
    $display("%0d edge results compared, %0d still outstanding", checked, awaiting);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
